/* rtl/pqadc_pkg.sv */
package pqadc_pkg;

  // Item kinds carried on the input tuser bit
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CODE = 1'b1
  } op_t;

  localparam int SUB_FIELD_W = 6;
  localparam int CEN_FIELD_W = 8;
  localparam int VAL_W       = 32;
  localparam int CODE_W      = 8;
  localparam int NSUB_W      = 7;
  localparam int SUM_W       = 38;

  // Input tdata layout, lowest field first
  localparam int SUB_LSB  = 0;
  localparam int CEN_LSB  = SUB_LSB + SUB_FIELD_W;
  localparam int VAL_LSB  = CEN_LSB + CEN_FIELD_W;
  localparam int CODE_LSB = VAL_LSB + VAL_W;
  localparam int IN_BITS  = CODE_LSB + CODE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

  localparam logic [NSUB_W-1:0] NSUB_RESET = NSUB_W'(8);

  // Index width used for counts and bounds up to 256
  localparam int IDX_W = 9;

endpackage

/* rtl/pq_adc_table_distance.sv */
// Channel      Direction  Payload
// s_axis       in         tuser: opcode; tdata: load_subspace, load_centroid,
//                         table_value, code (low to high)
// m_axis       out        tdata: distance (38-bit signed Q22.16)
// cfg          in         cfg_data: num_subspaces
//
// One word per cycle while s_axis_tready is high. A code word reads the table
// at accept; stage one adds the entry, and a candidate's last code moves the
// sum to the output register. s_axis_tready drops only while a finished sum
// waits in stage one behind an untaken result. Reset clears the counter, the
// sum and all valid flags; the table holds garbage until loaded.
module pq_adc_table_distance #(
  parameter int MAX_SUBSPACES = 64,
  parameter int CENTROIDS     = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [5:0] load_subspace, [13:6] load_centroid, [45:14] table_value,
  // [53:46] code, [55:54] zero
  input  logic [pqadc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] opcode
  input  logic [0:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [37:0] distance, [39:38] zero
  output logic [pqadc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pqadc_pkg::NSUB_W-1:0]          cfg_data
);
  import pqadc_pkg::*;

  localparam int SUB_W  = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
  localparam int CW     = $clog2(CENTROIDS);
  localparam int ADDR_W = SUB_W + CW;
  localparam int DEPTH  = MAX_SUBSPACES * (2 ** CW);
  localparam logic [IDX_W-1:0] MAX_SUB_I = IDX_W'(MAX_SUBSPACES);
  localparam logic [IDX_W-1:0] CEN_I     = IDX_W'(CENTROIDS);

  logic [VAL_W-1:0] mem [DEPTH];

  logic [NSUB_W-1:0]  num_subspaces;
  logic [SUB_W-1:0]   counter;
  logic [SUM_W-1:0]   sum;
  logic               s1_valid;
  logic               s1_last;
  logic               s1_hit;
  logic [VAL_W-1:0]   rd_data;
  logic               out_valid;
  logic [SUM_W-1:0]   out_data;

  op_t                op;
  logic               in_accept;
  logic               s1_stall;
  logic [IDX_W-1:0]   load_sub_i;
  logic [IDX_W-1:0]   load_cen_i;
  logic [IDX_W-1:0]   code_i;
  logic [IDX_W-1:0]   eff_count;
  logic [IDX_W-1:0]   counter_inc;
  logic               last0;
  logic               load_ok;
  logic               wr_en;
  logic               rd_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [SUM_W-1:0]   sum_next;

  assign op          = op_t'(s_axis_tuser[0]);
  assign s1_stall    = s1_valid && s1_last && out_valid && !m_axis_tready;
  assign s_axis_tready = !s1_stall;
  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready   = 1'b1;

  assign load_sub_i = IDX_W'(s_axis_tdata[SUB_LSB +: SUB_FIELD_W]);
  assign load_cen_i = IDX_W'(s_axis_tdata[CEN_LSB +: CEN_FIELD_W]);
  assign code_i     = IDX_W'(s_axis_tdata[CODE_LSB +: CODE_W]);
  assign load_ok    = (load_sub_i < MAX_SUB_I) && (load_cen_i < CEN_I);

  always_comb begin
    if (num_subspaces == '0) begin
      eff_count = IDX_W'(1);
    end else if (IDX_W'(num_subspaces) > MAX_SUB_I) begin
      eff_count = MAX_SUB_I;
    end else begin
      eff_count = IDX_W'(num_subspaces);
    end
  end

  assign counter_inc = IDX_W'(counter) + IDX_W'(1);
  assign last0       = counter_inc >= eff_count;

  assign wr_en   = in_accept && (op == OP_LOAD) && load_ok;
  assign rd_en   = in_accept && (op == OP_CODE);
  assign wr_addr = {load_sub_i[SUB_W-1:0], load_cen_i[CW-1:0]};
  assign rd_addr = {counter, code_i[CW-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= s_axis_tdata[VAL_LSB +: VAL_W];
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_subspaces <= NSUB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_subspaces <= cfg_data;
    end
  end

  // Advance the subspace counter at code accept; the add follows in stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (rd_en) begin
      counter <= last0 ? '0 : counter + SUB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_last <= last0;
      s1_hit  <= code_i < CEN_I;
    end
  end

  assign sum_next = sum + (s1_hit ? SUM_W'(signed'(rd_data)) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (s1_valid && !s1_stall) begin
      sum <= s1_last ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_last && !s1_stall) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_last && !s1_stall) begin
      out_data <= sum_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data);

  // Input backpressure comes only from a finished sum blocked at the output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && s1_last && m_axis_tvalid))
    else $error("input stalled without a blocked result");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    IDX_W'(counter) < MAX_SUB_I)
    else $error("subspace counter out of range");

  a_last_flows: assert property (@(posedge clk) disable iff (rst)
    (rd_en && last0) |=> (s1_valid && s1_last && counter == '0))
    else $error("last code did not reach stage one");

  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && !s1_stall) |=> (sum == '0 && m_axis_tvalid))
    else $error("sum not cleared after result");

endmodule

/* tb/pq_adc_table_distance_tb.sv */
module pq_adc_table_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pqadc_pkg::*;

  localparam int MAX_SUBS = 64;
  localparam int NUM_CENS = 256;
  localparam int HOLD_AT_RESULT = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    op_t               op;
    logic [SUB_FIELD_W-1:0] sub;
    logic [CEN_FIELD_W-1:0] cen;
    logic [VAL_W-1:0]  val;
    logic [CODE_W-1:0] code;
  } pq_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [NSUB_W-1:0]      cfg_data = '0;

  // words waiting for the driver, and distances waiting for the output
  pq_word_t         word_queue[$];
  logic [SUM_W-1:0] distance_queue[$];

  int err_cnt = 0;
  int res_cnt = 0;
  int cyc = 0;
  logic calm;

  // predictor state
  logic [VAL_W-1:0] dist_tbl [MAX_SUBS][NUM_CENS];
  int               pred_sub;
  logic [SUM_W-1:0] pred_sum;
  logic [NSUB_W-1:0] pred_nsub;
  logic [VAL_W-1:0] pred_entry;

  // stimulus-side tracking, keeps every code on a written entry
  bit                wr_flag [MAX_SUBS][NUM_CENS];
  int                wr_cnt [MAX_SUBS];
  int                gen_sub = 0;
  logic [NSUB_W-1:0] gen_nsub = NSUB_RESET;
  int                item_cnt = 0;

  // driver and receiver state
  pq_word_t drv_word;
  int       drv_gap = 0;
  int       rx_stall = 0;
  int       rx_hold = 0;
  bit       rx_hold_done = 1'b0;

  pq_adc_table_distance DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  // quiet stretches: no new gaps and no new random stalls on either side
  assign calm = ((cyc >> 8) % 4) == 0;

  function automatic int eff_count(logic [NSUB_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_SUBS) return MAX_SUBS;
    return int'(n);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VAL_W-1:0] rand_val();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h7FFF_FFFF;
    if (r < 20) return 32'h8000_0000;
    if (r < 25) return '0;
    return $urandom;
  endfunction

  task automatic push_load(int s, int c, logic [VAL_W-1:0] v);
    pq_word_t w;
    w.op   = OP_LOAD;
    w.sub  = SUB_FIELD_W'(s);
    w.cen  = CEN_FIELD_W'(c);
    w.val  = v;
    w.code = CODE_W'($urandom);
    word_queue.push_back(w);
    if (!wr_flag[s][c]) wr_cnt[s]++;
    wr_flag[s][c] = 1'b1;
    item_cnt++;
  endtask

  task automatic push_code(int c);
    pq_word_t w;
    w.op   = OP_CODE;
    w.sub  = SUB_FIELD_W'($urandom);
    w.cen  = CEN_FIELD_W'($urandom);
    w.val  = $urandom;
    w.code = CODE_W'(c);
    word_queue.push_back(w);
    gen_sub = (gen_sub + 1 >= eff_count(gen_nsub)) ? 0 : gen_sub + 1;
    item_cnt++;
  endtask

  task automatic push_rand_code();
    int c;
    if (wr_cnt[gen_sub] == 0)
      push_load(gen_sub, $urandom_range(0, NUM_CENS - 1), rand_val());
    c = $urandom_range(0, NUM_CENS - 1);
    while (!wr_flag[gen_sub][c]) c = (c + 1) % NUM_CENS;
    push_code(c);
  endtask

  task automatic random_phase(int n);
    int stop;
    stop = item_cnt + n;
    while (item_cnt < stop) begin
      if ($urandom_range(0, 99) < 20) begin
        push_load($urandom_range(0, MAX_SUBS - 1), $urandom_range(0, NUM_CENS - 1),
                  rand_val());
      end else begin
        // finish a whole candidate, with the odd load mixed in
        do begin
          if ($urandom_range(0, 99) < 12)
            push_load(gen_sub, $urandom_range(0, NUM_CENS - 1), rand_val());
          push_rand_code();
        end while (gen_sub != 0);
      end
    end
  endtask

  task automatic wait_drained();
    while (word_queue.size() != 0 || s_axis_tvalid || distance_queue.size() != 0)
      @(posedge clk);
    // let a code that ends no candidate leave the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_nsub(logic [NSUB_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gen_nsub = v;
  endtask

  // sender: hold the word until taken, then gap or advance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      drv_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (drv_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        drv_gap <= drv_gap - 1;
      end else if (word_queue.size() != 0) begin
        drv_word = word_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drv_word.op;
        s_axis_tdata  <= IN_TDATA_W'({drv_word.code, drv_word.val, drv_word.cen,
                                      drv_word.sub});
        drv_gap <= calm ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall <= 0;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!rx_hold_done && res_cnt >= HOLD_AT_RESULT) begin
      m_axis_tready <= 1'b0;
      rx_hold <= HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end else if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rx_stall <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // predict distances from accepted words
  always @(posedge clk) begin
    if (rst) begin
      pred_sub = 0;
      pred_sum = '0;
      pred_nsub = NSUB_RESET;
    end else begin
      if (cfg_valid && cfg_ready) pred_nsub = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        if (op_t'(s_axis_tuser[0]) == OP_LOAD) begin
          dist_tbl[s_axis_tdata[SUB_LSB +: SUB_FIELD_W]][s_axis_tdata[CEN_LSB +: CEN_FIELD_W]]
            = s_axis_tdata[VAL_LSB +: VAL_W];
        end else begin
          pred_entry = dist_tbl[pred_sub][s_axis_tdata[CODE_LSB +: CODE_W]];
          pred_sum = pred_sum + {{(SUM_W - VAL_W){pred_entry[VAL_W-1]}}, pred_entry};
          if (pred_sub + 1 >= eff_count(pred_nsub)) begin
            distance_queue.push_back(pred_sum);
            pred_sum = '0;
            pred_sub = 0;
          end else begin
            pred_sub++;
          end
        end
      end
    end
  end

  // compare each taken distance with the oldest prediction
  always @(posedge clk) begin
    logic [SUM_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      res_cnt++;
      if (distance_queue.size() == 0) begin
        $error("distance: unexpected word, actual %0d", $signed(m_axis_tdata[SUM_W-1:0]));
        err_cnt++;
      end else begin
        want = distance_queue.pop_front();
        if (m_axis_tdata[SUM_W-1:0] !== want) begin
          $error("distance mismatch: expected %0d actual %0d", $signed(want),
                 $signed(m_axis_tdata[SUM_W-1:0]));
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int s;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset count of 8: extreme positive entries, a load inside a candidate
    for (s = 0; s < 8; s++) push_load(s, 255, 32'h7FFF_FFFF);
    for (s = 0; s < 8; s++) begin
      if (s == 4) push_load(63, 0, 32'h8000_0000);
      push_code(255);
    end
    push_load(63, 255, 32'h8000_0000);
    push_load(0, 0, 32'h8000_0000);
    // lower the count while a candidate is half done
    for (s = 0; s < 5; s++) push_code(255);
    write_nsub(0);
    push_code(255);
    push_code(0);
    push_code(255);

    random_phase(200);
    write_nsub(1);
    random_phase(120);

    // widest count: entry 0 of every subspace at the positive, then the negative extreme
    write_nsub(64);
    for (s = 0; s < MAX_SUBS; s++) push_load(s, 0, 32'h7FFF_FFFF);
    for (s = 0; s < MAX_SUBS; s++) push_code(0);
    for (s = 0; s < MAX_SUBS; s++) push_load(s, 0, 32'h8000_0000);
    for (s = 0; s < MAX_SUBS; s++) push_code(0);
    random_phase(150);

    write_nsub(127);
    random_phase(100);
    write_nsub(0);
    random_phase(100);
    repeat (3) begin
      write_nsub(NSUB_W'($urandom_range(1, 12)));
      random_phase(120);
    end
    write_nsub(NSUB_W'($urandom_range(0, 127)));
    random_phase(100);

    wait_drained();
    if (distance_queue.size() != 0) begin
      $error("distance: %0d expected words never arrived", distance_queue.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
